// ----- src/vli_pkg.sv -----
package vli_pkg;

    // Field widths fixed by the stream format
    localparam int COORD_W     = 16;
    localparam int LENGTH_W    = 16;
    localparam int S_DATA_W    = 2 * COORD_W;
    localparam int M_DATA_W    = LENGTH_W;

    // Default component width actually used for the arithmetic
    localparam int COORD_BITS_DEF = 16;

    // Largest length that can come out: floor(sqrt(2^31))
    localparam logic [LENGTH_W-1:0] LENGTH_MAX = 16'd46340;

endpackage

// ----- src/vli_square.sv -----
module vli_square
    import vli_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      advance,
    input  logic                      in_valid,
    input  logic [COORD_W-1:0]        vec_x,
    input  logic [COORD_W-1:0]        vec_y,
    output logic                      sum_valid,
    output logic [2*COORD_BITS-1:0]   sum
);

    localparam int RAD_W = 2 * COORD_BITS;

    logic [COORD_BITS-1:0] mag_x;
    logic [COORD_BITS-1:0] mag_y;
    logic [RAD_W-1:0]      sq_x_reg;
    logic [RAD_W-1:0]      sq_y_reg;
    logic                  sq_valid_reg;
    logic [RAD_W-1:0]      sum_reg;
    logic                  sum_valid_reg;

    // Magnitudes of the low COORD_BITS bits taken as two's complement;
    // the most negative value maps to 2^(COORD_BITS-1), which still fits
    assign mag_x = vec_x[COORD_BITS-1] ? (~vec_x[COORD_BITS-1:0] + 1'b1)
                                       : vec_x[COORD_BITS-1:0];
    assign mag_y = vec_y[COORD_BITS-1] ? (~vec_y[COORD_BITS-1:0] + 1'b1)
                                       : vec_y[COORD_BITS-1:0];

    // Squares, registered
    always_ff @(posedge aclk) begin
        if (advance) begin
            sq_x_reg <= RAD_W'(mag_x) * RAD_W'(mag_x);
            sq_y_reg <= RAD_W'(mag_y) * RAD_W'(mag_y);
        end
    end

    // Radicand, registered
    always_ff @(posedge aclk) begin
        if (advance) begin
            sum_reg <= sq_x_reg + sq_y_reg;
        end
    end

    // Valid flags of both stages
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sq_valid_reg  <= 1'b0;
            sum_valid_reg <= 1'b0;
        end else if (advance) begin
            sq_valid_reg  <= in_valid;
            sum_valid_reg <= sq_valid_reg;
        end
    end

    assign sum       = sum_reg;
    assign sum_valid = sum_valid_reg;

endmodule

// ----- src/vli_cell.sv -----
module vli_cell
    import vli_pkg::*;
#(
    parameter int RAD_W   = 2 * COORD_BITS_DEF,
    parameter int BIT_POS = 2 * COORD_BITS_DEF - 2
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             advance,
    input  logic             in_valid,
    input  logic [RAD_W-1:0] in_rad,
    input  logic [RAD_W-1:0] in_res,
    output logic             out_valid,
    output logic [RAD_W-1:0] out_rad,
    output logic [RAD_W-1:0] out_res
);

    localparam logic [RAD_W-1:0] STEP_BIT = RAD_W'(1) << BIT_POS;

    logic [RAD_W-1:0] trial;
    logic [RAD_W:0]   diff;
    logic             fits;
    logic [RAD_W-1:0] rad_next;
    logic [RAD_W-1:0] res_next;
    logic             valid_reg;
    logic [RAD_W-1:0] rad_reg;
    logic [RAD_W-1:0] res_reg;

    // One restoring step: subtract the trial value if it fits
    assign trial    = in_res + STEP_BIT;
    assign diff     = {1'b0, in_rad} - {1'b0, trial};
    assign fits     = !diff[RAD_W];
    assign rad_next = fits ? diff[RAD_W-1:0] : in_rad;
    assign res_next = fits ? ((in_res >> 1) + STEP_BIT) : (in_res >> 1);

    always_ff @(posedge aclk) begin
        if (advance) begin
            rad_reg <= rad_next;
            res_reg <= res_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (advance) begin
            valid_reg <= in_valid;
        end
    end

    assign out_valid = valid_reg;
    assign out_rad   = rad_reg;
    assign out_res   = res_reg;

endmodule

// ----- src/vector_length_isqrt.sv -----
// Integer length of a signed 2-D vector, floor(sqrt(x*x + y*y)).
// Pipeline: two squaring/sum stages, then one cell per result bit.
// Throughput: one request per cycle unless the output is held; every stage holds while a
// result waits at the output, so the pipeline depth sets latency and not rate.
// Reset (aresetn low, synchronous) clears all valid flags; data registers keep their contents.
module vector_length_isqrt
    import vli_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,   // vec_x [15:0], vec_y [31:16]
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata    // length [15:0]
);

    localparam int RAD_W = 2 * COORD_BITS;

    logic             advance;
    logic             chain_valid [0:COORD_BITS];
    logic [RAD_W-1:0] chain_rad   [0:COORD_BITS];
    logic [RAD_W-1:0] chain_res   [0:COORD_BITS];

    // The whole chain moves together unless the output is held
    assign advance  = !m_tvalid || m_tready;
    assign s_tready = advance;

    // Magnitudes, squares and radicand
    vli_square #(
        .COORD_BITS (COORD_BITS)
    ) u_square (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .advance   (advance),
        .in_valid  (s_tvalid),
        .vec_x     (s_tdata[COORD_W-1:0]),
        .vec_y     (s_tdata[2*COORD_W-1:COORD_W]),
        .sum_valid (chain_valid[0]),
        .sum       (chain_rad[0])
    );

    assign chain_res[0] = '0;

    // Row of root cells, one result bit each, highest power of four first
    for (genvar i = 0; i < COORD_BITS; i++) begin : g_cell
        vli_cell #(
            .RAD_W   (RAD_W),
            .BIT_POS (RAD_W - 2 - 2 * i)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .advance   (advance),
            .in_valid  (chain_valid[i]),
            .in_rad    (chain_rad[i]),
            .in_res    (chain_res[i]),
            .out_valid (chain_valid[i+1]),
            .out_rad   (chain_rad[i+1]),
            .out_res   (chain_res[i+1])
        );
    end

    // Last cell register is the output register
    assign m_tvalid = chain_valid[COORD_BITS];
    assign m_tdata  = M_DATA_W'(chain_res[COORD_BITS][COORD_BITS-1:0]);

endmodule

// ----- src/vli_checker.sv -----
module vli_checker
    import vli_pkg::*;
(
    input logic                aclk,
    input logic                aresetn,
    input logic                s_tready,
    input logic                m_tvalid,
    input logic                m_tready,
    input logic [M_DATA_W-1:0] m_tdata
);

    // Output is empty straight after reset
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    // Input is taken exactly when the output slot is free or being drained
    a_ready_follows_output: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready == (!m_tvalid || m_tready))
        else $error("input ready does not follow output state");

    // A length never exceeds the root of the largest radicand
    a_length_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata <= LENGTH_MAX))
        else $error("length out of range");

    // A held result stays valid
    a_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> m_tvalid)
        else $error("result dropped while stalled");

    // A held result keeps its value
    a_hold_data: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> $stable(m_tdata))
        else $error("result changed while stalled");

endmodule

bind vector_length_isqrt vli_checker u_vli_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ----- dv/tb_vector_length_isqrt.sv -----
module tb_vector_length_isqrt;
    import vli_pkg::*;

    localparam int COORD_BITS  = COORD_BITS_DEF;
    localparam int LATENCY     = COORD_BITS + 2;
    localparam int CYCLE_LIMIT = 200000;

    // One accepted request and the length it must produce
    typedef struct {
        logic [COORD_W-1:0]  vec_x;
        logic [COORD_W-1:0]  vec_y;
        logic [LENGTH_W-1:0] length;
    } length_req_t;

    logic                aclk;
    logic                aresetn;
    logic                s_tvalid;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata;   // vec_x [15:0], vec_y [31:16]
    logic                m_tvalid;
    logic                m_tready;
    logic [M_DATA_W-1:0] m_tdata;   // length [15:0]

    length_req_t pending_lengths[$];
    bit          idle_on;
    int          reqs_sent;
    int          lengths_checked;
    int          mismatches;
    int          cycle_count;

    vector_length_isqrt #(
        .COORD_BITS(COORD_BITS)
    ) DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    // 20-unit clock
    initial aclk = 1'b0;
    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // Magnitude of a COORD_BITS-wide two's complement component
    function automatic logic [31:0] coord_mag(logic [COORD_W-1:0] raw);
        logic [31:0] mask;
        logic [31:0] sign;
        logic [31:0] v;
        mask = (32'd1 << COORD_BITS) - 32'd1;
        sign = 32'd1 << (COORD_BITS - 1);
        v = {16'd0, raw} & mask;
        if ((v & sign) != 0)
            v = (~v + 32'd1) & mask;
        return v;
    endfunction

    // floor(sqrt(x^2 + y^2)), restoring digit-by-digit root
    function automatic logic [LENGTH_W-1:0] vector_length(logic [COORD_W-1:0] vx,
                                                         logic [COORD_W-1:0] vy);
        logic [31:0] mx;
        logic [31:0] my;
        logic [31:0] rad;
        logic [31:0] root;
        logic [31:0] bitv;
        mx   = coord_mag(vx);
        my   = coord_mag(vy);
        rad  = mx * mx + my * my;
        root = 32'd0;
        bitv = 32'd1 << (2 * COORD_BITS - 2);
        for (int i = 0; i < COORD_BITS; i++) begin
            if (rad >= root + bitv) begin
                rad  = rad - (root + bitv);
                root = (root >> 1) + bitv;
            end else begin
                root = root >> 1;
            end
            bitv = bitv >> 2;
        end
        return root[LENGTH_W-1:0];
    endfunction

    // Result side: random backpressure, changed on the falling edge
    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            m_tready = idle_on ? ($urandom_range(0, 99) >= 8) : 1'b1;
        end
    end

    // Check each accepted length against the oldest pending request
    always @(posedge aclk) begin
        length_req_t req;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_lengths.size() == 0) begin
                $display("%0t: unexpected length: expected none, actual %0d", $time, m_tdata);
                mismatches++;
            end else begin
                req = pending_lengths.pop_front();
                lengths_checked++;
                if (m_tdata !== req.length) begin
                    $display("%0t: length mismatch for x=%0d y=%0d: expected %0d, actual %0d",
                             $time, $signed(req.vec_x), $signed(req.vec_y),
                             req.length, m_tdata);
                    mismatches++;
                end
            end
        end
    end

    // Watchdog
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("%0t: timeout, %0d lengths still pending", $time, pending_lengths.size());
        $display("tb_vector_length_isqrt: FAIL");
        $finish;
    end

    // Send one request; returns on the falling edge after acceptance
    task automatic send_vector(logic [COORD_W-1:0] vx, logic [COORD_W-1:0] vy);
        length_req_t req;
        while (idle_on && $urandom_range(0, 99) < 8) begin
            s_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata  = {vy, vx};
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        req.vec_x  = vx;
        req.vec_y  = vy;
        req.length = vector_length(vx, vy);
        pending_lengths.push_back(req);
        reqs_sent++;
        @(negedge aclk);
    endtask

    task automatic wait_drained();
        s_tvalid = 1'b0;
        while (pending_lengths.size() != 0)
            @(negedge aclk);
    endtask

    // Component drawn from one of several regions of the range
    function automatic logic [COORD_W-1:0] rand_coord();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 50)
            return COORD_W'($urandom);
        else if (pick < 70)
            return COORD_W'($urandom_range(0, 127) - 64);
        else if (pick < 85)
            case ($urandom_range(0, 3))
                0: return 16'h8000;
                1: return 16'h7FFF;
                2: return 16'h8001;
                default: return 16'hFFFF;
            endcase
        else
            return COORD_W'(1) << $urandom_range(0, COORD_W - 1);
    endfunction

    // Extremes and hand-picked vectors
    task automatic test_directed();
        send_vector(16'h0000, 16'h0000);
        send_vector(16'h0001, 16'h0000);
        send_vector(16'h0000, 16'hFFFF);
        send_vector(16'h7FFF, 16'h0000);
        send_vector(16'h0000, 16'h7FFF);
        send_vector(16'h8000, 16'h0000);
        send_vector(16'h0000, 16'h8000);
        // most negative in both: sum is exactly 2^31
        send_vector(16'h8000, 16'h8000);
        send_vector(16'h7FFF, 16'h7FFF);
        send_vector(16'h8001, 16'h8000);
        send_vector(16'h7FFF, 16'h8000);
        send_vector(16'hFFFF, 16'hFFFF);
        send_vector(16'd3, 16'd4);
        send_vector(-16'sd3, 16'd4);
        send_vector(16'd5, -16'sd12);
        send_vector(16'h5555, 16'hAAAA);
        send_vector(16'hAAAA, 16'h5555);
        // just either side of a perfect square radius
        send_vector(16'd255, 16'd0);
        send_vector(16'd255, 16'd22);
        send_vector(16'd255, 16'd23);
    endtask

    task automatic test_random_mix(int n);
        for (int i = 0; i < n; i++)
            send_vector(rand_coord(), rand_coord());
    endtask

    // Sender holds off until the pipeline is empty, then resumes
    task automatic test_drain_pause();
        test_random_mix(30);
        wait_drained();
        test_random_mix(30);
    endtask

    // Back-to-back requests with no stalls on either side
    task automatic test_no_idle(int n);
        idle_on = 1'b0;
        test_random_mix(n);
        idle_on = 1'b1;
    endtask

    initial begin
        aresetn         = 1'b0;
        s_tvalid        = 1'b0;
        s_tdata         = '0;
        idle_on         = 1'b1;
        reqs_sent       = 0;
        lengths_checked = 0;
        mismatches      = 0;
        repeat (3) @(negedge aclk);
        aresetn = 1'b1;

        test_directed();
        test_random_mix(900);
        test_drain_pause();
        test_no_idle(300);
        test_random_mix(270);

        wait_drained();
        repeat (LATENCY + 4) @(posedge aclk);
        $display("Sent %0d vector requests (extremes, small, power-of-two and full-range",
                 reqs_sent);
        $display("components) and checked %0d lengths, %0d mismatches.",
                 lengths_checked, mismatches);
        if (mismatches == 0 && pending_lengths.size() == 0) begin
            $display("tb_vector_length_isqrt: PASS");
        end else begin
            $display("tb_vector_length_isqrt: FAIL");
        end
        $finish;
    end

endmodule

// ----- files.f -----
src/vli_pkg.sv
src/vli_square.sv
src/vli_cell.sv
src/vector_length_isqrt.sv
src/vli_checker.sv
dv/tb_vector_length_isqrt.sv
